/* design/lr_pkg.sv */
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared widths, controller states and the command and status types that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package lr_pkg;

  // Default tile size exponent and the fixed field widths of the channels.
  localparam int COORD_BITS_DEFAULT = 6;
  localparam int FIELD_BITS         = 6;
  localparam int RGB_BITS           = 24;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ORIENT,
    ST_PREP,
    ST_DRAW
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic orient;
    logic prep;
    logic step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } status_t;

endpackage

/* design/lr_line_if.sv */
// ----------------------------------------------------------------------------
// Line request channel
// Carries one line as two endpoints with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface lr_line_if;
  logic                         valid;
  logic                         ready;
  logic [lr_pkg::FIELD_BITS-1:0] start_x;
  logic [lr_pkg::FIELD_BITS-1:0] start_y;
  logic [lr_pkg::FIELD_BITS-1:0] end_x;
  logic [lr_pkg::FIELD_BITS-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

/* design/lr_pixel_if.sv */
// ----------------------------------------------------------------------------
// Pixel channel
// Carries one plotted pixel per request with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface lr_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [lr_pkg::FIELD_BITS-1:0] pixel_x;
  logic [lr_pkg::FIELD_BITS-1:0] pixel_y;
  logic [lr_pkg::RGB_BITS-1:0]   pixel_rgb;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_rgb, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_rgb, last_pixel, output ready);
endinterface

/* design/lr_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the pixel color register value with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface lr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lr_pkg::RGB_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* design/lr_ctrl.sv */
// ----------------------------------------------------------------------------
// Line rasterizer controller
// Sequences capture, axis selection, setup and the per-pixel drawing steps.
// ----------------------------------------------------------------------------
module lr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  lr_pkg::status_t status,
  output lr_pkg::cmd_t    cmd
);

  lr_pkg::state_t state;
  lr_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state logic.
  always_comb begin
    state_next = state;
    case (state)
      lr_pkg::ST_IDLE: begin
        if (in_valid) state_next = lr_pkg::ST_ORIENT;
      end
      lr_pkg::ST_ORIENT: begin
        state_next = lr_pkg::ST_PREP;
      end
      lr_pkg::ST_PREP: begin
        state_next = lr_pkg::ST_DRAW;
      end
      lr_pkg::ST_DRAW: begin
        if (out_ready && status.last) state_next = lr_pkg::ST_IDLE;
      end
      default: begin
        state_next = lr_pkg::ST_IDLE;
      end
    endcase
  end

  // Output logic: handshakes and datapath commands.
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state)
      lr_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      lr_pkg::ST_ORIENT: begin
        cmd.orient = 1'b1;
      end
      lr_pkg::ST_PREP: begin
        cmd.prep = 1'b1;
      end
      lr_pkg::ST_DRAW: begin
        out_valid = 1'b1;
        cmd.step  = out_ready && !status.last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* design/lr_datapath.sv */
// ----------------------------------------------------------------------------
// Line rasterizer datapath
// Holds the endpoints, the Bresenham error term and the current pixel.
// ----------------------------------------------------------------------------
module lr_datapath #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  lr_pkg::cmd_t                  cmd,
  output lr_pkg::status_t               status,
  input  logic [lr_pkg::FIELD_BITS-1:0] start_x,
  input  logic [lr_pkg::FIELD_BITS-1:0] start_y,
  input  logic [lr_pkg::FIELD_BITS-1:0] end_x,
  input  logic [lr_pkg::FIELD_BITS-1:0] end_y,
  input  logic                          color_we,
  input  logic                          color_rst,
  input  logic [lr_pkg::RGB_BITS-1:0]   color_data,
  output logic [lr_pkg::FIELD_BITS-1:0] pixel_x,
  output logic [lr_pkg::FIELD_BITS-1:0] pixel_y,
  output logic [lr_pkg::RGB_BITS-1:0]   pixel_rgb,
  output logic                          last_pixel
);

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 3;

  // Captured endpoints, masked to the tile.
  logic [CB-1:0] x0, y0, x1, y1;
  // Endpoints in major and minor order after the swap.
  logic [CB-1:0] m_start, n_start, m_end, n_end;
  logic          major_is_y;
  // Drawing state.
  logic [CB-1:0]        cur_major, cur_minor;
  logic signed [EW-1:0] error_term;
  logic signed [EW-1:0] inc_diag, inc_straight;
  logic [CB:0]          steps_left;
  logic                 minor_step_negative;
  logic [lr_pkg::RGB_BITS-1:0] pixel_color;

  // Axis choice and swap, computed from the captured endpoints.
  logic [CB-1:0] adx, ady, ma, na, mb, nb;
  logic          y_major;
  always_comb begin
    adx     = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady     = (y1 > y0) ? y1 - y0 : y0 - y1;
    y_major = !(ady < adx);
    ma      = y_major ? y0 : x0;
    na      = y_major ? x0 : y0;
    mb      = y_major ? y1 : x1;
    nb      = y_major ? x1 : y1;
  end

  // Spans along both axes and the direction of the minor axis.
  logic [CB-1:0]        dmaj, dmin;
  logic                 neg;
  logic signed [EW-1:0] dmaj_s, dmin_s;
  always_comb begin
    dmaj   = m_end - m_start;
    neg    = n_end < n_start;
    dmin   = neg ? n_start - n_end : n_end - n_start;
    dmaj_s = EW'(dmaj);
    dmin_s = EW'(dmin);
  end

  // Capture the endpoints of an accepted request.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x0 <= start_x[CB-1:0];
      y0 <= start_y[CB-1:0];
      x1 <= end_x[CB-1:0];
      y1 <= end_y[CB-1:0];
    end
  end

  // Order the endpoints so the major coordinate counts upward.
  always_ff @(posedge clk) begin
    if (cmd.orient) begin
      major_is_y <= y_major;
      if (ma > mb) begin
        m_start <= mb;
        n_start <= nb;
        m_end   <= ma;
        n_end   <= na;
      end else begin
        m_start <= ma;
        n_start <= na;
        m_end   <= mb;
        n_end   <= nb;
      end
    end
  end

  // Set up the walk, then advance one pixel per accepted pixel.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      cur_major           <= m_start;
      cur_minor           <= n_start;
      minor_step_negative <= neg;
      error_term          <= (dmin_s <<< 1) - dmaj_s;
      inc_diag            <= (dmin_s - dmaj_s) <<< 1;
      inc_straight        <= dmin_s <<< 1;
      steps_left          <= {1'b0, dmaj} + (CB+1)'(1);
    end else if (cmd.step) begin
      cur_major  <= cur_major + CB'(1);
      steps_left <= steps_left - (CB+1)'(1);
      if (error_term > 0) begin
        cur_minor  <= minor_step_negative ? cur_minor - CB'(1) : cur_minor + CB'(1);
        error_term <= error_term + inc_diag;
      end else begin
        error_term <= error_term + inc_straight;
      end
    end
  end

  // Color register; a write may arrive at any time and applies to the pixel on offer.
  always_ff @(posedge clk) begin
    if (color_rst) begin
      pixel_color <= '0;
    end else if (color_we) begin
      pixel_color <= color_data;
    end
  end

  // Pixel outputs.
  assign status.last = (steps_left == (CB+1)'(1));
  assign pixel_x     = lr_pkg::FIELD_BITS'(major_is_y ? cur_minor : cur_major);
  assign pixel_y     = lr_pkg::FIELD_BITS'(major_is_y ? cur_major : cur_minor);
  assign pixel_rgb   = pixel_color;
  assign last_pixel  = status.last;

endmodule

/* design/line_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// Line rasterizer unit
// Bresenham line drawing in a square tile of 2^COORD_BITS pixels per side.
// ----------------------------------------------------------------------------
// A request is one line given by two endpoints; the unit returns every pixel
// of the line in order along the major axis, both endpoints included, each
// tagged with the configured color and a last-pixel flag. After a request is
// taken the unit passes through an orient state that chooses the major axis
// and a prep state that sets up the error term, then offers one pixel per
// cycle while the pixel side does not stall; the next request is taken in the
// cycle after the last pixel is delivered. The pixel rate is set by the single
// error-term update loop in the datapath.
module line_rasterizer_unit #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  lr_line_if.sink    line,
  lr_pixel_if.source pixel,
  lr_cfg_if.sink     cfg
);

  lr_pkg::cmd_t    cmd;
  lr_pkg::status_t status;

  // The color register takes a write at any time.
  assign cfg.ready = 1'b1;

  // Controller.
  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (line.valid),
    .in_ready  (line.ready),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  lr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .start_x    (line.start_x),
    .start_y    (line.start_y),
    .end_x      (line.end_x),
    .end_y      (line.end_y),
    .color_we   (cfg.valid),
    .color_rst  (rst),
    .color_data (cfg.data),
    .pixel_x    (pixel.pixel_x),
    .pixel_y    (pixel.pixel_y),
    .pixel_rgb  (pixel.pixel_rgb),
    .last_pixel (pixel.last_pixel)
  );

  // A new line is never taken while a pixel is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(line.ready && pixel.valid))
    else $error("request taken while a pixel is pending");

  // The first pixel follows an accepted line after the setup cycles.
  a_setup_latency: assert property (@(posedge clk) disable iff (rst)
    (line.valid && line.ready) |=> !pixel.valid ##1 !pixel.valid ##1 pixel.valid)
    else $error("first pixel not offered after setup");

  // After the last pixel the unit is ready for the next line.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready && pixel.last_pixel) |=> line.ready)
    else $error("unit not idle after the last pixel");

  // A pixel that is not the last is always followed by another.
  a_more_pixels: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready && !pixel.last_pixel) |=> pixel.valid)
    else $error("line ended without a last pixel");

endmodule

/* sim/line_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer pixel checker
// Watches the line, pixel and color channels of the rasterizer. Every line
// request taken is expanded into its Bresenham pixels with the current color.
// Every pixel delivered is compared field by field with the oldest pixel
// still outstanding.
// ----------------------------------------------------------------------------
module line_checker #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  lr_line_if   line,
  lr_pixel_if  pixel,
  lr_cfg_if    cfg,
  output int   fail_count,
  output int   pending
);

  localparam int COORD_MASK = (1 << COORD_BITS) - 1;

  typedef struct packed {
    logic [lr_pkg::FIELD_BITS-1:0] x;
    logic [lr_pkg::FIELD_BITS-1:0] y;
    logic [lr_pkg::RGB_BITS-1:0]   rgb;
    logic                          last;
  } drawn_pixel_t;

  // Color register copy and the pixels still owed by the block.
  logic [lr_pkg::RGB_BITS-1:0] pixel_color = '0;
  drawn_pixel_t                expected_pixels[$];
  int                          mismatch_count = 0;

  // Expand one line into its pixels, walking upward along the major axis.
  function automatic void rasterize_line(input logic [lr_pkg::FIELD_BITS-1:0] sx,
                                         input logic [lr_pkg::FIELD_BITS-1:0] sy,
                                         input logic [lr_pkg::FIELD_BITS-1:0] ex,
                                         input logic [lr_pkg::FIELD_BITS-1:0] ey);
    int x0, y0, x1, y1, adx, ady;
    int maj0, min0, maj1, min1, swap;
    int span_major, span_minor, minor_step, err, m, n;
    bit major_y;
    drawn_pixel_t p;
    x0  = int'(sx) & COORD_MASK;
    y0  = int'(sy) & COORD_MASK;
    x1  = int'(ex) & COORD_MASK;
    y1  = int'(ey) & COORD_MASK;
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    // Equal spans and single points step along y.
    major_y = !(ady < adx);
    if (major_y) begin
      maj0 = y0; min0 = x0; maj1 = y1; min1 = x1;
    end else begin
      maj0 = x0; min0 = y0; maj1 = x1; min1 = y1;
    end
    if (maj0 > maj1) begin
      swap = maj0; maj0 = maj1; maj1 = swap;
      swap = min0; min0 = min1; min1 = swap;
    end
    span_major = maj1 - maj0;
    span_minor = min1 - min0;
    minor_step = 1;
    if (span_minor < 0) begin
      minor_step = -1;
      span_minor = -span_minor;
    end
    err = 2 * span_minor - span_major;
    n   = min0;
    for (m = maj0; m <= maj1; m++) begin
      p.x    = lr_pkg::FIELD_BITS'((major_y ? n : m) & COORD_MASK);
      p.y    = lr_pkg::FIELD_BITS'((major_y ? m : n) & COORD_MASK);
      p.rgb  = pixel_color;
      p.last = (m == maj1);
      expected_pixels.push_back(p);
      if (err > 0) begin
        n   += minor_step;
        err += 2 * (span_minor - span_major);
      end else begin
        err += 2 * span_minor;
      end
    end
  endfunction

  // Sample all three channels at the rising edge and check delivered pixels.
  always @(posedge clk) begin
    drawn_pixel_t want;
    if (rst) begin
      pixel_color = '0;
      expected_pixels.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        pixel_color = cfg.data;
      end
      if (pixel.valid && pixel.ready) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: pixel (%0d,%0d) rgb %h last %b delivered with none outstanding",
                     $realtime, pixel.pixel_x, pixel.pixel_y, pixel.pixel_rgb,
                     pixel.last_pixel);
          end
        end else begin
          want = expected_pixels.pop_front();
          if (pixel.pixel_x !== want.x || pixel.pixel_y !== want.y ||
              pixel.pixel_rgb !== want.rgb || pixel.last_pixel !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: expected (%0d,%0d) rgb %h last %b, got (%0d,%0d) rgb %h last %b",
                       $realtime, want.x, want.y, want.rgb, want.last,
                       pixel.pixel_x, pixel.pixel_y, pixel.pixel_rgb, pixel.last_pixel);
            end
          end
        end
      end
      if (line.valid && line.ready) begin
        rasterize_line(line.start_x, line.start_y, line.end_x, line.end_y);
      end
    end
    fail_count <= mismatch_count;
    pending    <= expected_pixels.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Sends directed and random line requests through the rasterizer under
// several pixel colors, with random gaps on the request side and random
// stalls on the pixel side. A separate checker predicts and compares the
// pixels; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STUCK_LIMIT  = 2000;
  localparam int RANDOM_LINES = 48;

  logic clk = 1'b0;
  logic rst;
  bit   stall_on;
  int   stall_left;
  int   stuck_cycles = 0;
  int   fail_count;
  int   pending;

  lr_line_if  line_ch ();
  lr_pixel_if pixel_ch ();
  lr_cfg_if   cfg_ch ();

  line_rasterizer_unit DUT (
    .clk   (clk),
    .rst   (rst),
    .line  (line_ch),
    .pixel (pixel_ch),
    .cfg   (cfg_ch)
  );

  line_checker u_line_checker (
    .clk        (clk),
    .rst        (rst),
    .line       (line_ch),
    .pixel      (pixel_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Length of one idle stretch: mostly short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Pixel side back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    if (!stall_on) begin
      pixel_ch.ready = 1'b1;
      stall_left     = 0;
    end else if (stall_left > 0) begin
      pixel_ch.ready = 1'b0;
      stall_left--;
    end else begin
      pixel_ch.ready = 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left = gap_len();
    end
  end

  // Give up when no channel has moved a request for too long.
  always @(posedge clk) begin
    if (rst || (line_ch.valid && line_ch.ready) || (pixel_ch.valid && pixel_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Present one line request after an optional idle gap and wait until taken.
  task automatic send_line(input logic [5:0] sx, input logic [5:0] sy,
                           input logic [5:0] ex, input logic [5:0] ey, input int gap);
    repeat (gap) begin
      @(negedge clk);
      line_ch.valid = 1'b0;
    end
    @(negedge clk);
    line_ch.valid   = 1'b1;
    line_ch.start_x = sx;
    line_ch.start_y = sy;
    line_ch.end_x   = ex;
    line_ch.end_y   = ey;
    do @(posedge clk); while (!line_ch.ready);
  endtask

  // Drop the request valid and wait until every pixel has been delivered.
  task automatic drain();
    @(negedge clk);
    line_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the pixel color register while the block is idle.
  task automatic write_color(input logic [lr_pkg::RGB_BITS-1:0] color);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = color;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Random line: a mix of long, short, axis-aligned, diagonal, point and edge lines.
  task automatic random_lines(input int count, input bit gaps_on);
    int r, k, gap;
    logic [5:0] sx, sy, ex, ey;
    for (int i = 0; i < count; i++) begin
      r  = $urandom_range(0, 99);
      sx = 6'($urandom_range(0, 63));
      sy = 6'($urandom_range(0, 63));
      ex = 6'($urandom_range(0, 63));
      ey = 6'($urandom_range(0, 63));
      if (r >= 45 && r < 65) begin
        ex = sx + 6'($urandom_range(0, 8) - 4);
        ey = sy + 6'($urandom_range(0, 8) - 4);
      end else if (r >= 65 && r < 75) begin
        if (r[0]) ey = sy;
        else ex = sx;
      end else if (r >= 75 && r < 82) begin
        k  = $urandom_range(0, 63);
        sx = 6'($urandom_range(0, 63 - k));
        sy = 6'($urandom_range(0, 63 - k));
        ex = sx + 6'(k);
        ey = sy + 6'(k);
        if (r[0]) begin
          sy = ey;
          ey = ey - 6'(k);
        end
      end else if (r >= 82 && r < 90) begin
        ex = sx;
        ey = sy;
      end else if (r >= 90) begin
        sx = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        sy = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        ex = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        ey = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      end
      gap = (gaps_on && $urandom_range(0, 1)) ? gap_len() : 0;
      send_line(sx, sy, ex, ey, gap);
    end
  endtask

  initial begin
    rst             = 1'b1;
    stall_on        = 1'b0;
    line_ch.valid   = 1'b0;
    line_ch.start_x = '0;
    line_ch.start_y = '0;
    line_ch.end_x   = '0;
    line_ch.end_y   = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed lines under the reset color, back to back with no stalls.
    send_line(0, 0, 0, 0, 0);        // single point at the origin
    send_line(63, 63, 63, 63, 0);    // single point at the far corner
    send_line(0, 0, 63, 0, 0);       // full-width horizontal
    send_line(63, 63, 0, 63, 0);     // horizontal drawn right to left
    send_line(0, 0, 0, 63, 0);       // full-height vertical
    send_line(63, 63, 63, 0, 0);     // vertical drawn downward
    send_line(0, 0, 63, 63, 0);      // diagonal, equal spans step along y
    send_line(63, 0, 0, 63, 0);      // anti-diagonal, minor axis decreasing
    send_line(0, 63, 63, 0, 0);
    send_line(0, 10, 63, 0, 0);      // shallow, minor axis decreasing
    send_line(63, 0, 0, 10, 0);      // same line with endpoints swapped
    send_line(10, 0, 0, 63, 0);      // steep, minor axis decreasing
    send_line(5, 5, 9, 8, 0);        // x span one more than y span
    send_line(5, 5, 8, 9, 0);        // y span one more than x span
    send_line(20, 20, 21, 20, 0);    // two pixels along x
    send_line(20, 20, 20, 19, 0);    // two pixels along y, reversed
    send_line(0, 32, 63, 31, 0);
    send_line(1, 62, 62, 1, 0);
    send_line(42, 21, 21, 42, 0);
    send_line(63, 1, 0, 0, 0);
    drain();

    // Random phases, each under a new color and one of several idling patterns.
    write_color(24'hFFFFFF);
    stall_on = 1'b1;
    random_lines(RANDOM_LINES, 1'b1);
    drain();

    write_color(24'h000000);
    random_lines(RANDOM_LINES, 1'b0);
    drain();

    write_color(24'($urandom));
    stall_on = 1'b0;
    random_lines(RANDOM_LINES, 1'b1);
    drain();

    write_color(24'($urandom));
    stall_on = 1'b1;
    random_lines(RANDOM_LINES, 1'b1);
    drain();

    write_color(24'($urandom));
    stall_on = 1'b0;
    random_lines(RANDOM_LINES, 1'b0);
    drain();

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
